// ----- rtl/rpt_pkg.sv -----
`timescale 1ns / 1ps
// shared widths, command and status codes for the random permutation table
package rpt_pkg;

	// fixed field widths
	localparam int CFG_W  = 11;
	localparam int FRAC_W = 16;
	localparam int VAL_W  = 10;
	localparam int SLOT_W = 10;
	localparam int CMD_W  = 2;
	localparam int ST_W   = 2;

	// table size after reset
	localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

	// command codes
	localparam logic [CMD_W-1:0] CMD_FILL   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DRAW   = 2'd2;

	// status codes
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

endpackage

// ----- rtl/random_permutation_table_core.sv -----
`timescale 1ns / 1ps
// random permutation table: linear probing insert, in-order draw, one shared probe unit
// Insert: answered in idle when full, else S_MUL then S_PROBE, one occupied slot per cycle.
// Draw: answered in idle when not ready, else via S_DRAW after one registered memory read.
// Start fill: done after the one-slot-a-cycle clearing pass over all MAX_ENTRIES marks.
// Unused command: accepted, no done. One command at a time; busy is high while one is in flight.
// After reset the same clearing pass runs over all MAX_ENTRIES slots with busy high; config
// writes are taken throughout. done is a one-cycle strobe; the receiver cannot stall.
module random_permutation_table_core #(
	parameter int MAX_ENTRIES = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// command side
	input  logic                          start,
	output logic                          busy,
	input  logic [rpt_pkg::CMD_W-1:0]     command,
	input  logic [rpt_pkg::FRAC_W-1:0]    random_fraction,
	// result side
	output logic                          done,
	output logic [rpt_pkg::VAL_W-1:0]     value,
	output logic [rpt_pkg::SLOT_W-1:0]    slot,
	output logic [rpt_pkg::ST_W-1:0]      status,
	// configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rpt_pkg::CFG_W-1:0]     perm_size
);

	localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W  = (CNT_W > rpt_pkg::CFG_W) ? CNT_W : rpt_pkg::CFG_W;
	localparam int PROD_W = CNT_W + rpt_pkg::FRAC_W;
	localparam int WORD_W = rpt_pkg::VAL_W + 1;

	localparam logic [CMP_W-1:0] MAX_EXT  = CMP_W'(MAX_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);
	localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_ENTRIES);

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CLEAR = 3'd1;
	localparam logic [2:0] S_MUL   = 3'd2;
	localparam logic [2:0] S_PROBE = 3'd3;
	localparam logic [2:0] S_DRAW  = 3'd4;

	logic [2:0]                     state_q;
	logic [rpt_pkg::CFG_W-1:0]      size_cfg_q;
	logic [rpt_pkg::FRAC_W-1:0]     frac_q;
	logic [CNT_W-1:0]               ins_cnt_q;
	logic [CNT_W-1:0]               dp_q;
	logic [CNT_W-1:0]               probe_n_q;
	logic [IDX_W-1:0]               pos_q;
	logic [IDX_W-1:0]               clr_idx_q;
	logic                           clr_emit_q;
	logic                           done_q;
	logic [rpt_pkg::VAL_W-1:0]      value_q;
	logic [rpt_pkg::SLOT_W-1:0]     slot_q;
	logic [rpt_pkg::ST_W-1:0]       status_q;

	// memory: occupied mark on top, stored value below
	logic [WORD_W-1:0]              mem [MAX_ENTRIES];
	logic [WORD_W-1:0]              rd_q;
	logic                           mem_we;
	logic [IDX_W-1:0]               mem_wa;
	logic [WORD_W-1:0]              mem_wd;
	logic [IDX_W-1:0]               mem_ra;
	logic                           rd_mark;

	logic [CMP_W-1:0]               size_ext;
	logic [CNT_W-1:0]               sz;
	logic [PROD_W-1:0]              prod;
	logic [IDX_W-1:0]               start_pos;
	logic [CNT_W-1:0]               pos_inc;
	logic [IDX_W-1:0]               pos_nxt;
	logic [CNT_W-1:0]               probe_inc;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign value     = value_q;
	assign slot      = slot_q;
	assign status    = status_q;
	assign rd_mark   = rd_q[WORD_W-1];

	// effective size: zero acts as one, clamp to the table depth
	always_comb begin
		size_ext = CMP_W'(size_cfg_q);
		if (size_ext == '0) begin
			sz = CNT_W'(1);
		end else if (size_ext > MAX_EXT) begin
			sz = MAX_CNT;
		end else begin
			sz = CNT_W'(size_ext);
		end
	end

	// start slot from the scaled fraction
	assign prod      = PROD_W'(sz) * PROD_W'(frac_q);
	assign start_pos = IDX_W'(prod >> rpt_pkg::FRAC_W);

	// shared probe step: next slot with wraparound, probe count
	assign pos_inc   = CNT_W'(pos_q) + CNT_W'(1);
	assign pos_nxt   = (pos_inc >= sz) ? '0 : IDX_W'(pos_inc);
	assign probe_inc = probe_n_q + CNT_W'(1);

	// memory port selection
	always_comb begin
		case (state_q)
			S_MUL:   mem_ra = start_pos;
			S_PROBE: mem_ra = pos_nxt;
			S_IDLE:  mem_ra = IDX_W'(dp_q);
			default: mem_ra = pos_q;
		endcase
		mem_we = (state_q == S_CLEAR) || ((state_q == S_PROBE) && !rd_mark);
		if (state_q == S_CLEAR) begin
			mem_wa = clr_idx_q;
			mem_wd = '0;
		end else begin
			mem_wa = pos_q;
			mem_wd = {1'b1, rpt_pkg::VAL_W'(ins_cnt_q)};
		end
	end

	// table memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[mem_ra];
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_cfg_q <= rpt_pkg::CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			size_cfg_q <= perm_size;
		end
	end

	// sequencer and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			frac_q     <= '0;
			ins_cnt_q  <= '0;
			dp_q       <= '0;
			probe_n_q  <= '0;
			pos_q      <= '0;
			clr_idx_q  <= '0;
			clr_emit_q <= 1'b0;
			done_q     <= 1'b0;
			value_q    <= '0;
			slot_q     <= '0;
			status_q   <= rpt_pkg::ST_OK;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						frac_q <= random_fraction;
						case (command)
							rpt_pkg::CMD_FILL: begin
								ins_cnt_q  <= '0;
								dp_q       <= '0;
								clr_idx_q  <= '0;
								clr_emit_q <= 1'b1;
								state_q    <= S_CLEAR;
							end
							rpt_pkg::CMD_INSERT: begin
								if (ins_cnt_q >= sz) begin
									done_q   <= 1'b1;
									value_q  <= '0;
									slot_q   <= '0;
									status_q <= rpt_pkg::ST_FULL;
								end else begin
									state_q <= S_MUL;
								end
							end
							rpt_pkg::CMD_DRAW: begin
								if ((ins_cnt_q < sz) || (dp_q >= sz)) begin
									done_q   <= 1'b1;
									value_q  <= '0;
									slot_q   <= '0;
									status_q <= rpt_pkg::ST_EMPTY;
								end else begin
									state_q <= S_DRAW;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + IDX_W'(1);
					if (clr_idx_q == LAST_IDX) begin
						state_q    <= S_IDLE;
						clr_emit_q <= 1'b0;
						if (clr_emit_q) begin
							done_q   <= 1'b1;
							value_q  <= '0;
							slot_q   <= '0;
							status_q <= rpt_pkg::ST_OK;
						end
					end
				end
				S_MUL: begin
					pos_q     <= start_pos;
					probe_n_q <= '0;
					state_q   <= S_PROBE;
				end
				S_PROBE: begin
					if (!rd_mark) begin
						done_q    <= 1'b1;
						value_q   <= rpt_pkg::VAL_W'(ins_cnt_q);
						slot_q    <= rpt_pkg::SLOT_W'(pos_q);
						status_q  <= rpt_pkg::ST_OK;
						ins_cnt_q <= ins_cnt_q + CNT_W'(1);
						state_q   <= S_IDLE;
					end else if (probe_inc >= sz) begin
						done_q   <= 1'b1;
						value_q  <= '0;
						slot_q   <= '0;
						status_q <= rpt_pkg::ST_FULL;
						state_q  <= S_IDLE;
					end else begin
						pos_q     <= pos_nxt;
						probe_n_q <= probe_inc;
					end
				end
				S_DRAW: begin
					done_q <= 1'b1;
					if (!rd_mark) begin
						value_q  <= '0;
						slot_q   <= '0;
						status_q <= rpt_pkg::ST_EMPTY;
					end else begin
						value_q  <= rd_q[rpt_pkg::VAL_W-1:0];
						slot_q   <= rpt_pkg::SLOT_W'(dp_q);
						status_q <= rpt_pkg::ST_OK;
						dp_q     <= dp_q + CNT_W'(1);
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// a word only follows an accepted command or a command in flight
	a_done_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(start && !busy) || $past(state_q != S_IDLE)))
		else $error("result word without a command");

	// the draw pointer never overtakes the inserted count
	a_draw_behind_insert: assert property (@(posedge clk) disable iff (!arst_n)
		dp_q <= ins_cnt_q)
		else $error("draw pointer ahead of insert count");

	// the inserted count stays within the table
	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		ins_cnt_q <= MAX_CNT)
		else $error("insert count beyond table depth");

endmodule

// ----- dv/rpt_result_check.sv -----
`timescale 1ns / 1ps
// result checker for the random permutation table: tracks the table and compares every word
module rpt_result_check #(
	parameter int MAX_ENTRIES = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  logic [rpt_pkg::CMD_W-1:0]  command,
	input  logic [rpt_pkg::FRAC_W-1:0] random_fraction,
	input  logic                       done,
	input  logic [rpt_pkg::VAL_W-1:0]  value,
	input  logic [rpt_pkg::SLOT_W-1:0] slot,
	input  logic [rpt_pkg::ST_W-1:0]   status,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [rpt_pkg::CFG_W-1:0]  perm_size,
	output int                         fails,
	output int                         pending_words
);

	typedef struct packed {
		logic [rpt_pkg::VAL_W-1:0]  value;
		logic [rpt_pkg::SLOT_W-1:0] slot;
		logic [rpt_pkg::ST_W-1:0]   status;
	} rpt_word_t;

	// words still to come from the block, oldest first
	rpt_word_t expected_words[$];

	// own copy of the table
	logic [rpt_pkg::VAL_W-1:0] perm_mem [MAX_ENTRIES];
	bit                        taken [MAX_ENTRIES];
	int unsigned               inserted;
	int unsigned               draw_idx;
	logic [rpt_pkg::CFG_W-1:0] size_reg;

	// permutation length actually in force
	function automatic int unsigned live_size();
		int unsigned s;
		s = size_reg;
		if (s == 0) s = 1;
		if (s > MAX_ENTRIES) s = MAX_ENTRIES;
		return s;
	endfunction

	// apply one accepted command to the table and queue the word it gives
	task automatic apply_command(input logic [rpt_pkg::CMD_W-1:0] cmd,
			input logic [rpt_pkg::FRAC_W-1:0] frac);
		rpt_word_t   w;
		int unsigned sz;
		int unsigned pos;
		bit          placed;
		sz = live_size();
		w = '{value: '0, slot: '0, status: rpt_pkg::ST_OK};
		case (cmd)
			rpt_pkg::CMD_FILL: begin
				foreach (taken[i]) taken[i] = 1'b0;
				inserted = 0;
				draw_idx = 0;
			end
			rpt_pkg::CMD_INSERT: begin
				if (inserted >= sz) begin
					w.status = rpt_pkg::ST_FULL;
				end else begin
					// scaled start slot, then linear probe with wraparound
					pos = (sz * frac) >> rpt_pkg::FRAC_W;
					placed = 1'b0;
					for (int unsigned n = 0; n < sz && !placed; n++) begin
						if (!taken[pos]) begin
							perm_mem[pos] = inserted[rpt_pkg::VAL_W-1:0];
							taken[pos] = 1'b1;
							w.value = inserted[rpt_pkg::VAL_W-1:0];
							w.slot = pos[rpt_pkg::SLOT_W-1:0];
							inserted++;
							placed = 1'b1;
						end else begin
							pos = (pos + 1 >= sz) ? 0 : pos + 1;
						end
					end
					if (!placed) w.status = rpt_pkg::ST_FULL;
				end
			end
			rpt_pkg::CMD_DRAW: begin
				if (inserted < sz || draw_idx >= sz || !taken[draw_idx]) begin
					w.status = rpt_pkg::ST_EMPTY;
				end else begin
					w.value = perm_mem[draw_idx];
					w.slot = draw_idx[rpt_pkg::SLOT_W-1:0];
					draw_idx++;
				end
			end
			default: return;
		endcase
		expected_words.push_back(w);
	endtask

	// watch the three channels at every edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_words.delete();
			foreach (taken[i]) taken[i] = 1'b0;
			inserted = 0;
			draw_idx = 0;
			size_reg = rpt_pkg::CFG_RESET;
			fails = 0;
			pending_words = 0;
		end else begin
			// result word first: it belongs to an earlier command
			if (done) begin
				if (expected_words.size() == 0) begin
					$display("%0t: result word with none expected, value %0d slot %0d status %0d",
						$time, value, slot, status);
					fails++;
				end else begin
					rpt_word_t w;
					w = expected_words.pop_front();
					if (value !== w.value) begin
						$display("%0t: value expected %0d actual %0d", $time, w.value, value);
						fails++;
					end
					if (slot !== w.slot) begin
						$display("%0t: slot expected %0d actual %0d", $time, w.slot, slot);
						fails++;
					end
					if (status !== w.status) begin
						$display("%0t: status expected %0d actual %0d", $time, w.status, status);
						fails++;
					end
				end
			end
			if (cfg_valid && cfg_ready) size_reg = perm_size;
			if (start && !busy) apply_command(command, random_fraction);
			pending_words = expected_words.size();
		end
	end

endmodule

// ----- dv/random_permutation_table_core_tb.sv -----
`timescale 1ns / 1ps
// testbench top for the random permutation table: command stimulus, size changes and verdict
module random_permutation_table_core_tb;

	localparam logic [rpt_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic                       busy;
	logic [rpt_pkg::CMD_W-1:0]  command = rpt_pkg::CMD_FILL;
	logic [rpt_pkg::FRAC_W-1:0] random_fraction = '0;
	logic                       done;
	logic [rpt_pkg::VAL_W-1:0]  value;
	logic [rpt_pkg::SLOT_W-1:0] slot;
	logic [rpt_pkg::ST_W-1:0]   status;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [rpt_pkg::CFG_W-1:0]  perm_size = rpt_pkg::CFG_RESET;

	int fails;
	int pending_words;
	int items_sent = 0;

	random_permutation_table_core DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.command         (command),
		.random_fraction (random_fraction),
		.done            (done),
		.value           (value),
		.slot            (slot),
		.status          (status),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.perm_size       (perm_size)
	);

	rpt_result_check result_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.command         (command),
		.random_fraction (random_fraction),
		.done            (done),
		.value           (value),
		.slot            (slot),
		.status          (status),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.perm_size       (perm_size),
		.fails           (fails),
		.pending_words   (pending_words)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// fraction with the two extremes turning up often
	function automatic logic [rpt_pkg::FRAC_W-1:0] pick_fraction();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return rpt_pkg::FRAC_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// present one command word and hold it until the block takes it
	task automatic issue(input logic [rpt_pkg::CMD_W-1:0] cmd,
			input logic [rpt_pkg::FRAC_W-1:0] frac);
		// no idling in the middle stretch of the run
		while (!(items_sent >= 150 && items_sent < 250) && $urandom_range(99) < 37) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		random_fraction <= frac;
		do @(posedge clk); while (busy);
		if (cmd != CMD_UNUSED) items_sent++;
	endtask

	// wait until every word is back and the block has gone quiet
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending_words != 0 || busy);
		repeat (4) @(posedge clk);
	endtask

	// new table size, written only with the block idle unless still clearing after reset
	task automatic write_size(input logic [rpt_pkg::CFG_W-1:0] sz, input bit settle);
		if (settle) drain();
		while ($urandom_range(99) < 37) @(posedge clk);
		cfg_valid <= 1'b1;
		perm_size <= sz;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// main stimulus
	initial begin
		int unsigned pick;
		int unsigned sz;
		int unsigned len;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// single entry table: draw before filled, insert, insert when full, exhausted draw
		write_size(11'd1, 1'b0);
		issue(rpt_pkg::CMD_DRAW, 16'h0000);
		issue(rpt_pkg::CMD_INSERT, 16'hFFFF);
		issue(rpt_pkg::CMD_INSERT, 16'h0000);
		issue(rpt_pkg::CMD_DRAW, 16'h5555);
		issue(rpt_pkg::CMD_DRAW, 16'hAAAA);
		issue(CMD_UNUSED, 16'hFFFF);
		issue(rpt_pkg::CMD_FILL, 16'hFFFF);
		// zero size acts as one
		write_size(11'd0, 1'b1);
		issue(rpt_pkg::CMD_INSERT, 16'h1234);
		issue(rpt_pkg::CMD_DRAW, 16'h0000);
		// shrink under a part-filled table: draw hits a free slot, insert sees it full
		write_size(11'd4, 1'b1);
		issue(rpt_pkg::CMD_FILL, 16'h0000);
		issue(rpt_pkg::CMD_INSERT, 16'h8000);
		issue(rpt_pkg::CMD_INSERT, 16'hC000);
		write_size(11'd2, 1'b1);
		issue(rpt_pkg::CMD_DRAW, 16'h0000);
		issue(rpt_pkg::CMD_INSERT, 16'h0000);
		// grow again: probes wrap past the end
		write_size(11'd4, 1'b1);
		issue(rpt_pkg::CMD_INSERT, 16'hFFFF);
		issue(rpt_pkg::CMD_INSERT, 16'h0000);
		issue(rpt_pkg::CMD_DRAW, 16'h0000);
		issue(rpt_pkg::CMD_DRAW, 16'h0000);
		// draw pointer beyond a shrunk size
		write_size(11'd1, 1'b1);
		issue(rpt_pkg::CMD_DRAW, 16'h0000);
		// oversize acts as the full table
		write_size(11'd2047, 1'b1);
		issue(rpt_pkg::CMD_FILL, 16'h0000);
		issue(rpt_pkg::CMD_INSERT, 16'hFFFF);
		issue(rpt_pkg::CMD_INSERT, 16'hFFFF);
		issue(rpt_pkg::CMD_INSERT, 16'h0001);
		issue(rpt_pkg::CMD_DRAW, 16'h0000);

		// random phases: mostly fill, insert to full, draw out, with noise mixed in
		while (items_sent < 380) begin
			pick = $urandom_range(99);
			if (pick < 8) sz = $urandom_range(1025, 2047);
			else if (pick < 12) sz = 0;
			else if (pick < 22) sz = $urandom_range(17, 32);
			else sz = $urandom_range(1, 16);
			write_size(rpt_pkg::CFG_W'(sz), 1'b1);
			len = (sz == 0) ? 1 : (sz > 1024) ? 1024 : sz;
			if (len > 96 || $urandom_range(99) < 15) begin
				repeat ($urandom_range(3, 10))
					issue(rpt_pkg::CMD_W'($urandom_range(0, 3)), pick_fraction());
			end else begin
				// sometimes carry on from whatever the table already holds
				if ($urandom_range(3) != 0) issue(rpt_pkg::CMD_FILL, pick_fraction());
				repeat (len) begin
					if ($urandom_range(15) == 0)
						issue(rpt_pkg::CMD_W'($urandom_range(0, 3)), pick_fraction());
					issue(rpt_pkg::CMD_INSERT, pick_fraction());
				end
				repeat (len + $urandom_range(0, 2)) begin
					if ($urandom_range(15) == 0) issue(rpt_pkg::CMD_INSERT, pick_fraction());
					issue(rpt_pkg::CMD_DRAW, pick_fraction());
				end
			end
		end

		// let the last words come back
		drain();
		repeat (20) @(posedge clk);
		if (fails == 0 && pending_words == 0)
			$display("random_permutation_table_core_tb: PASS");
		else
			$display("random_permutation_table_core_tb: FAIL");
		$finish;
	end

	// hang guard
	initial begin
		#10000000;
		$display("random_permutation_table_core_tb: FAIL");
		$finish;
	end

endmodule
